[sv/timed_actuator_position_estimator_unit_macros.svh]
// Assertion macros shared by the estimator RTL.
`ifndef TIMED_ACTUATOR_POSITION_ESTIMATOR_UNIT_MACROS_SVH
`define TIMED_ACTUATOR_POSITION_ESTIMATOR_UNIT_MACROS_SVH

// Check an implication on every clock unless reset is high.
`define TAPE_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check an implication on the next clock unless reset is high.
`define TAPE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/tape_pkg.sv]
`timescale 1ns / 1ps
package tape_pkg;

   localparam int MODULES_DEF = 4;
   localparam int MOD_W       = 4;
   localparam int POS_W       = 8;
   localparam int EST_W       = 16;
   localparam int TIME_W      = 24;
   localparam int MPU_W       = 20;
   localparam int CSR_W       = 20;
   localparam int CSR_IDX_W   = 3;
   localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};
   localparam logic [15:0] HCOUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_STOP   = 2'd2,
      MODE_HOME   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_OUT    = 3'd1,
      ST_IN     = 3'd2,
      ST_HDRIVE = 3'd3,
      ST_HBRAKE = 3'd4
   } motion_type;

   typedef enum logic [2:0] {
      CSR_MAX_POS  = 3'd0,
      CSR_MIN_CHG  = 3'd1,
      CSR_MPU      = 3'd2,
      CSR_DRIVE    = 3'd3,
      CSR_HDUTY    = 3'd4,
      CSR_HTICKS   = 3'd5,
      CSR_BTICKS   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [MOD_W-1:0] module_req;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [MOD_W-1:0] module_out;
      logic [2:0]       motion_state;
      logic [7:0]       forward_duty;
      logic [7:0]       reverse_duty;
      logic [POS_W-1:0] current_position;
      logic             any_moving;
      logic             homing_done;
      logic             last;
   } rsp_type;

   // Request to the shared multiply/divide unit.
   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [EST_W-1:0]  a;
      logic [TIME_W-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] result;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_DISPATCH,
      SQ_TGT_MUL,
      SQ_TGT_WAIT,
      SQ_TGT_FIN,
      SQ_TICK_CHK,
      SQ_TICK_DIV,
      SQ_TICK_WAIT,
      SQ_TICK_FIN,
      SQ_NEXT,
      SQ_EMIT,
      SQ_EMIT_WAIT
   } seq_type;

   function automatic logic [POS_W-1:0] round_clamp(input logic [EST_W-1:0] est,
                                                    input logic [POS_W-1:0] maxp);
      logic [POS_W:0] r;
      r = (POS_W+1)'(({1'b0, est} + 17'd128) >> 8);
      round_clamp = (r > {1'b0, maxp}) ? maxp : r[POS_W-1:0];
   endfunction

endpackage

[sv/tape_alu.sv]
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply (16 x 24 -> top bits) or
// restoring divide (40-bit dividend / 24-bit divisor), one bit per cycle.
module tape_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  tape_pkg::alu_cmd_type cmd,
   output tape_pkg::alu_rsp_type rsp,
   input  logic [39:0]           dividend
);
   import tape_pkg::*;

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [39:0] acc_ff, acc_in;       // product or quotient/dividend shift
   logic [24:0] rem_ff, rem_in;
   logic [23:0] opb_ff, opb_in;
   logic [15:0] opa_ff, opa_in;
   logic        done_ff, done_in;
   logic [24:0] trial;

   assign trial = {rem_ff[23:0], acc_ff[39]} - {1'b0, opb_ff};

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      opb_in  = opb_ff;
      opa_in  = opa_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         opb_in  = cmd.b;
         opa_in  = cmd.a;
         rem_in  = '0;
         acc_in  = cmd.is_div ? dividend : 40'd0;
         cnt_in  = cmd.is_div ? 6'd40 : 6'd16;
      end else if (busy_ff) begin
         if (div_ff) begin
            // Shift one dividend bit in, subtract when it fits.
            if (!trial[24]) begin
               rem_in = trial;
               acc_in = {acc_ff[38:0], 1'b1};
            end else begin
               rem_in = {rem_ff[23:0], acc_ff[39]};
               acc_in = {acc_ff[38:0], 1'b0};
            end
         end else begin
            // Add the multiplicand for each multiplier bit, MSB first.
            acc_in = {acc_ff[38:0], 1'b0} + (opa_ff[15] ? {16'd0, opb_ff} : 40'd0);
            opa_in = {opa_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      opb_ff <= opb_in;
      opa_ff <= opa_in;
   end

   // Multiply returns bits [39:16]; divide returns the low quotient bits.
   assign rsp.done   = done_ff;
   assign rsp.result = div_ff ? acc_ff[23:0] : acc_ff[39:16];

endmodule

[sv/timed_actuator_position_estimator_unit.sv]
`timescale 1ns / 1ps
// Order: a set target is dispatched, multiplied and finished; a tick, unless
// homing, visits each module in turn and divides for each moving one short of
// its travel time; other requests go straight to their results. MODULES results
// then follow one per cycle when not stalled. One request is handled at a time,
// taken again the cycle after its last result; the bit-serial ALU sets the time.
// Reset: synchronous, active high; all modules idle at zero, registers default.
module timed_actuator_position_estimator_unit #(
   parameter int MODULES = tape_pkg::MODULES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tape_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tape_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [19:0]              csr_wdata
);
   import tape_pkg::*;
   `include "timed_actuator_position_estimator_unit_macros.svh"

   localparam int MI_W = (MODULES > 1) ? $clog2(MODULES) : 1;

   // Configuration registers
   logic [7:0]  max_pos_ff, min_chg_ff, drive_ff, hduty_ff;
   logic [19:0] mpu_ff;
   logic [15:0] hticks_ff, bticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pos_ff <= 8'd255;
         min_chg_ff <= 8'd1;
         mpu_ff     <= 20'd25600;
         drive_ff   <= 8'd200;
         hduty_ff   <= 8'd255;
         hticks_ff  <= 16'd10000;
         bticks_ff  <= 16'd200;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_POS: max_pos_ff <= csr_wdata[7:0];
            CSR_MIN_CHG: min_chg_ff <= csr_wdata[7:0];
            CSR_MPU:     mpu_ff     <= csr_wdata;
            CSR_DRIVE:   drive_ff   <= csr_wdata[7:0];
            CSR_HDUTY:   hduty_ff   <= csr_wdata[7:0];
            CSR_HTICKS:  hticks_ff  <= csr_wdata[15:0];
            CSR_BTICKS:  bticks_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Per-module state
   motion_type       mode_ff  [MODULES];
   logic [15:0]      est_ff   [MODULES];
   logic [15:0]      start_ff [MODULES];
   logic [7:0]       goal_ff  [MODULES];
   logic [23:0]      tt_ff    [MODULES];
   logic [23:0]      el_ff    [MODULES];
   logic [15:0]      hcnt_ff;
   logic             homed_ff;

   seq_type          sq_ff, sq_in;
   req_type          rq_ff;
   logic [MI_W-1:0]  idx_ff;
   logic [15:0]      dist_ff;
   logic             up_ff;
   logic [MI_W-1:0]  m_idx;

   alu_cmd_type      acmd;
   alu_rsp_type      arsp;
   logic [39:0]      dividend;

   tape_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (acmd),
      .rsp      (arsp),
      .dividend (dividend)
   );

   logic homing;
   assign homing = (mode_ff[0] == ST_HDRIVE) || (mode_ff[0] == ST_HBRAKE);
   assign m_idx  = (sq_ff == SQ_DISPATCH) ? rq_ff.module_req[MI_W-1:0] : idx_ff;

   // Quantities for the current module
   logic [7:0]  tpos;
   logic [7:0]  gdiff;
   logic [15:0] g16_t, g16_k;
   logic [15:0] tdist, kdist;
   logic        req_ok;
   logic [23:0] eln_next;
   always_comb begin
      tpos   = (rq_ff.position > max_pos_ff) ? max_pos_ff : rq_ff.position;
      gdiff  = (tpos > goal_ff[m_idx]) ? tpos - goal_ff[m_idx] : goal_ff[m_idx] - tpos;
      g16_t  = {tpos, 8'd0};
      tdist  = (g16_t > est_ff[m_idx]) ? g16_t - est_ff[m_idx] : est_ff[m_idx] - g16_t;
      g16_k  = {goal_ff[m_idx], 8'd0};
      kdist  = (g16_k > start_ff[m_idx]) ? g16_k - start_ff[m_idx]
                                         : start_ff[m_idx] - g16_k;
      req_ok = (MODULES >= 16) ||
               (rq_ff.module_req < MOD_W'(MODULES));
   end

   assign eln_next = (el_ff[idx_ff] < ELAPSED_MAX) ? el_ff[idx_ff] + 24'd1 : el_ff[idx_ff];

   // Sequencer next state
   always_comb begin
      sq_in = sq_ff;
      unique case (sq_ff)
         SQ_IDLE:     if (req_valid) sq_in = SQ_DISPATCH;
         SQ_DISPATCH: begin
            unique case (mode_type'(rq_ff.mode))
               MODE_TICK:   sq_in = homing ? SQ_EMIT : SQ_TICK_CHK;
               MODE_TARGET: sq_in = (!homing && req_ok && gdiff >= min_chg_ff)
                                    ? SQ_TGT_MUL : SQ_EMIT;
               default:     sq_in = SQ_EMIT;
            endcase
         end
         SQ_TGT_MUL:   sq_in = SQ_TGT_WAIT;
         SQ_TGT_WAIT:  if (arsp.done) sq_in = SQ_TGT_FIN;
         SQ_TGT_FIN:   sq_in = SQ_EMIT;
         SQ_TICK_CHK: begin
            if ((mode_ff[idx_ff] == ST_OUT || mode_ff[idx_ff] == ST_IN) &&
                tt_ff[idx_ff] != 24'd0 && eln_next < tt_ff[idx_ff])
               sq_in = SQ_TICK_DIV;
            else
               sq_in = SQ_NEXT;
         end
         SQ_TICK_DIV:  sq_in = SQ_TICK_WAIT;
         SQ_TICK_WAIT: if (arsp.done) sq_in = SQ_TICK_FIN;
         SQ_TICK_FIN:  sq_in = SQ_NEXT;
         SQ_NEXT:      sq_in = (idx_ff == MI_W'(MODULES - 1)) ? SQ_EMIT : SQ_TICK_CHK;
         SQ_EMIT:      sq_in = SQ_EMIT_WAIT;
         SQ_EMIT_WAIT: if (!rsp_stall && idx_ff == MI_W'(MODULES - 1)) sq_in = SQ_IDLE;
         default:      sq_in = SQ_IDLE;
      endcase
   end

   // Dividend is |delta| * elapsed; formed by a 16x24 product registered first.
   logic [39:0] prod_ff;
   always_ff @(posedge clock) prod_ff <= 40'(kdist) * 40'(eln_next);
   assign dividend = prod_ff;

   // ALU command
   always_comb begin
      acmd = '0;
      if (sq_ff == SQ_TGT_MUL) begin
         acmd.start  = 1'b1;
         acmd.is_div = 1'b0;
         acmd.a      = dist_ff;
         acmd.b      = {4'd0, mpu_ff};
      end else if (sq_ff == SQ_TICK_DIV) begin
         acmd.start  = 1'b1;
         acmd.is_div = 1'b1;
         acmd.b      = tt_ff[idx_ff];
      end
   end

   // Output staging
   logic any;
   always_comb begin
      any = 1'b0;
      for (int i = 0; i < MODULES; i++) if (mode_ff[i] != ST_IDLE) any = 1'b1;
   end

   always_comb begin
      rsp_data = '0;
      rsp_data.module_out       = MOD_W'(idx_ff);
      rsp_data.motion_state     = mode_ff[idx_ff];
      unique case (mode_ff[idx_ff])
         ST_OUT:    rsp_data.forward_duty = drive_ff;
         ST_IN:     rsp_data.reverse_duty = drive_ff;
         ST_HDRIVE: rsp_data.reverse_duty = hduty_ff;
         ST_HBRAKE: begin
            rsp_data.forward_duty = 8'd255;
            rsp_data.reverse_duty = 8'd255;
         end
         default: ;
      endcase
      rsp_data.current_position = round_clamp(est_ff[idx_ff], max_pos_ff);
      rsp_data.any_moving       = any;
      rsp_data.homing_done      = homed_ff;
      rsp_data.last             = (idx_ff == MI_W'(MODULES - 1));
   end

   assign rsp_valid = (sq_ff == SQ_EMIT_WAIT);
   assign req_stall = (sq_ff != SQ_IDLE);

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff    <= SQ_IDLE;
         idx_ff   <= '0;
         hcnt_ff  <= '0;
         homed_ff <= 1'b0;
         for (int i = 0; i < MODULES; i++) begin
            mode_ff[i]  <= ST_IDLE;
            est_ff[i]   <= '0;
            start_ff[i] <= '0;
            goal_ff[i]  <= '0;
            tt_ff[i]    <= '0;
            el_ff[i]    <= '0;
         end
      end else begin
         sq_ff <= sq_in;
         unique case (sq_ff)
            SQ_IDLE: begin
               rq_ff  <= req_data;
               idx_ff <= '0;
            end
            SQ_DISPATCH: begin
               unique case (mode_type'(rq_ff.mode))
                  MODE_TICK: begin
                     if (homing) begin
                        // Advance the homing phase counter; at its limit, brake or finish homing.
                        if ((hcnt_ff < HCOUNT_MAX ? hcnt_ff + 16'd1 : hcnt_ff) >=
                            ((mode_ff[0] == ST_HDRIVE) ? hticks_ff : bticks_ff)) begin
                           hcnt_ff <= '0;
                           for (int i = 0; i < MODULES; i++) begin
                              if (mode_ff[0] == ST_HDRIVE) mode_ff[i] <= ST_HBRAKE;
                              else begin
                                 mode_ff[i]  <= ST_IDLE;
                                 est_ff[i]   <= '0;
                                 start_ff[i] <= '0;
                                 goal_ff[i]  <= '0;
                                 tt_ff[i]    <= '0;
                                 el_ff[i]    <= '0;
                              end
                           end
                           if (mode_ff[0] == ST_HBRAKE) homed_ff <= 1'b1;
                        end else if (hcnt_ff < HCOUNT_MAX) begin
                           hcnt_ff <= hcnt_ff + 16'd1;
                        end
                     end
                  end
                  MODE_TARGET: begin
                     idx_ff  <= m_idx;
                     dist_ff <= tdist;
                     up_ff   <= g16_t > est_ff[m_idx];
                     if (sq_in == SQ_TGT_MUL) begin
                        goal_ff[m_idx]  <= tpos;
                        start_ff[m_idx] <= est_ff[m_idx];
                        el_ff[m_idx]    <= '0;
                     end
                  end
                  MODE_STOP: begin
                     if (!homing) begin
                        for (int i = 0; i < MODULES; i++) begin
                           goal_ff[i] <= round_clamp(est_ff[i], max_pos_ff);
                           mode_ff[i] <= ST_IDLE;
                        end
                     end
                  end
                  MODE_HOME: begin
                     homed_ff <= 1'b0;
                     hcnt_ff  <= '0;
                     for (int i = 0; i < MODULES; i++) mode_ff[i] <= ST_HDRIVE;
                  end
                  default: ;
               endcase
            end
            SQ_TGT_FIN: begin
               tt_ff[idx_ff] <= arsp.result;
               if (arsp.result == 24'd0 || dist_ff < 16'd128) begin
                  est_ff[idx_ff]  <= {goal_ff[idx_ff], 8'd0};
                  mode_ff[idx_ff] <= ST_IDLE;
               end else begin
                  mode_ff[idx_ff] <= up_ff ? ST_OUT : ST_IN;
               end
            end
            SQ_TICK_CHK: begin
               up_ff  <= g16_k > start_ff[idx_ff];
               if (mode_ff[idx_ff] == ST_OUT || mode_ff[idx_ff] == ST_IN) begin
                  if (tt_ff[idx_ff] == 24'd0) begin
                     est_ff[idx_ff]  <= g16_k;
                     mode_ff[idx_ff] <= ST_IDLE;
                  end else begin
                     el_ff[idx_ff] <= eln_next;
                     if (eln_next >= tt_ff[idx_ff]) begin
                        est_ff[idx_ff]  <= g16_k;
                        mode_ff[idx_ff] <= ST_IDLE;
                     end
                  end
               end
            end
            SQ_TICK_FIN: begin
               est_ff[idx_ff] <= up_ff ? start_ff[idx_ff] + arsp.result[15:0]
                                       : start_ff[idx_ff] - arsp.result[15:0];
            end
            SQ_NEXT: if (sq_in == SQ_TICK_CHK) idx_ff <= idx_ff + MI_W'(1);
            SQ_EMIT: idx_ff <= '0;
            SQ_EMIT_WAIT: if (!rsp_stall && sq_in != SQ_IDLE) idx_ff <= idx_ff + MI_W'(1);
            default: ;
         endcase
      end
   end

   logic rsp_last_fire;
   assign rsp_last_fire = rsp_valid && !rsp_stall && rsp_data.last;

   `TAPE_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, req_stall, "result while idle")
   `TAPE_ASSERT_NEXT(a_last_done, clock, reset, rsp_last_fire, !rsp_valid, "result after last")
   `TAPE_ASSERT_IMP(a_home_sync, clock, reset, mode_ff[0] == ST_HDRIVE, homing, "homing flag mismatch")

endmodule
